// ===== rtl/fses_pkg.sv =====
`default_nettype none

package fses_pkg;

  localparam int MAX_NOTES   = 8;
  localparam int NUM_EFFECTS = 12;
  localparam int ROM_EFFECTS = 12;
  localparam int ROM_NOTES   = 8;
  localparam int EFFECT_LIMIT = (NUM_EFFECTS < ROM_EFFECTS) ? NUM_EFFECTS : ROM_EFFECTS;

  localparam logic [2:0] CHANNEL_RESET = 3'd4;

  // register map
  localparam logic [7:0] KEY_ADDR      = 8'h08;
  localparam logic [7:0] KEY_ON_BITS   = 8'h48;
  localparam logic [7:0] ALG_ADDR      = 8'h20;
  localparam logic [7:0] ALG_VALUE     = 8'hc7;
  localparam logic [7:0] PMS_ADDR      = 8'h38;
  localparam logic [7:0] KEYCODE_ADDR  = 8'h28;
  localparam logic [7:0] FRAC_ADDR     = 8'h30;
  localparam logic [7:0] OP_BASE_ADDR  = 8'h40;
  localparam logic [7:0] OP_AR_VALUE   = 8'h1f;
  localparam logic [7:0] OP_RR_VALUE   = 8'hff;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_INIT  = 3'd3,
    KIND_FINAL = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_KEYOFF = 2'd0,
    CMD_NOTE   = 2'd1,
    CMD_START  = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  // Write counts per command
  localparam logic [4:0] LEN_KEYOFF = 5'd1;
  localparam logic [4:0] LEN_NOTE   = 5'd4;
  localparam logic [4:0] LEN_START  = 5'd16;
  localparam logic [4:0] LEN_INIT   = 5'd27;

  typedef struct packed {
    cmd_e       code;
    logic [3:0] effect;
    logic [7:0] key;
  } cmd_t;

  localparam logic [7:0] NOTE_KEY [ROM_EFFECTS][ROM_NOTES] = '{
    '{8'h5a, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h38, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4e, 8'h5a, 8'h66, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4a, 8'h52, 8'h5a, 8'h4a, 8'h52, 8'h5a, 8'h6e, 8'h00},
    '{8'h46, 8'h52, 8'h5e, 8'h6a, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h4e, 8'h5a, 8'h66, 8'h72, 8'h00, 8'h00, 8'h00},
    '{8'h36, 8'h2a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h42, 8'h32, 8'h4a, 8'h36, 8'h52, 8'h00, 8'h00, 8'h00},
    '{8'h4a, 8'h5a, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3e, 8'h46, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] NOTE_DUR [ROM_EFFECTS][ROM_NOTES] = '{
    '{3'd1, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd0},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
  };

  localparam logic [3:0] NOTE_COUNT [ROM_EFFECTS] = '{
    4'd2, 4'd2, 4'd1, 4'd1, 4'd4, 4'd7, 4'd4, 4'd5, 4'd2, 4'd5, 4'd3, 4'd3
  };

  // op0 multiple, tl, decay; op3 multiple, tl, decay
  localparam logic [7:0] PATCH [ROM_EFFECTS][6] = '{
    '{8'h01, 8'h0c, 8'h10, 8'h01, 8'h24, 8'h18},
    '{8'h01, 8'h18, 8'h18, 8'h01, 8'h30, 8'h1f},
    '{8'h06, 8'h18, 8'h1f, 8'h01, 8'h08, 8'h1f},
    '{8'h01, 8'h18, 8'h1f, 8'h01, 8'h02, 8'h1f},
    '{8'h03, 8'h18, 8'h10, 8'h01, 8'h10, 8'h10},
    '{8'h02, 8'h18, 8'h18, 8'h01, 8'h14, 8'h14},
    '{8'h03, 8'h08, 8'h10, 8'h01, 8'h20, 8'h18},
    '{8'h05, 8'h10, 8'h1c, 8'h02, 8'h18, 8'h16},
    '{8'h01, 8'h04, 8'h1f, 8'h01, 8'h10, 8'h1f},
    '{8'h07, 8'h04, 8'h1f, 8'h06, 8'h0c, 8'h1f},
    '{8'h02, 8'h0c, 8'h14, 8'h01, 8'h26, 8'h18},
    '{8'h04, 8'h18, 8'h0c, 8'h01, 8'h30, 8'h14}
  };

  function automatic logic [3:0] effect_len(input logic [3:0] eff);
    logic [3:0] n;
    n = NOTE_COUNT[eff];
    if (n > 4'(MAX_NOTES)) n = 4'(MAX_NOTES);
    if (n > 4'(ROM_NOTES)) n = 4'(ROM_NOTES);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fm_sound_effect_sequencer.sv =====
// FM sound effect sequencer.
// Input channel (in_valid_i/in_ready_o, kind_i, effect_i) takes tick, start,
// stop, initialize and finalize requests. Output channel (out_valid_o/
// out_ready_i) delivers synthesizer register writes: reg_addr_o, reg_value_o,
// with last_o high on the final write caused by one request.
// cfg_we_i/cfg_wdata_i set the synthesizer channel; write it only while idle.
// The front stage updates playback state when a request is accepted and
// queues a command; a two-entry queue feeds the back stage, which emits one
// write per cycle from the output register while the receiver is ready.
// A request's first write goes through the queue, then the output register.
// Throughput: one write per cycle while the receiver is ready; initialize
// makes 27 writes, start 16, a new note 4, key off 1, other requests none.
// Requests are taken every cycle while the queue has room, so up to two
// commands may be queued, counting the one whose writes are being emitted.
// When the receiver stalls, the current write holds and the queue fills;
// in_ready_o drops once it is full.
// Reset: not initialized, not playing, channel 4, queue and output empty.
`default_nettype none

module fm_sound_effect_sequencer (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire  [2:0] cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [2:0] kind_i,
  input  wire  [3:0] effect_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] reg_addr_o,
  output logic [7:0] reg_value_o,
  output logic       last_o
);
  import fses_pkg::*;

  logic       push, full, pop, head_valid;
  cmd_t       push_cmd, head_cmd;
  logic [2:0] channel;

  fses_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .effect_i    (effect_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .channel_o   (channel)
  );

  fses_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .valid_o (head_valid)
  );

  fses_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .channel_i    (channel),
    .head_i       (head_cmd),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .reg_addr_o   (reg_addr_o),
    .reg_value_o  (reg_value_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/fses_front.sv =====
`default_nettype none

module fses_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [2:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [2:0]          kind_i,
  input  wire  [3:0]          effect_i,
  input  wire                 full_i,
  output logic                push_o,
  output fses_pkg::cmd_t      cmd_o,
  output logic [2:0]          channel_o
);
  import fses_pkg::*;

  logic       channel_changed;
  logic [2:0] channel_q;
  logic       ready_q, ready_d;
  logic       playing_q, playing_d;
  logic [3:0] cur_eff_q, cur_eff_d;
  logic [2:0] step_q, step_d;
  logic [2:0] ticks_q, ticks_d;
  logic       accept;
  logic       has_cmd;
  logic [3:0] next_step;
  logic [3:0] cur_len;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign next_step  = {1'b0, step_q} + 4'd1;
  assign cur_len    = effect_len(cur_eff_q);
  assign channel_o  = channel_q;
  assign channel_changed = cfg_we_i;

  always_comb begin
    ready_d   = ready_q;
    playing_d = playing_q;
    cur_eff_d = cur_eff_q;
    step_d    = step_q;
    ticks_d   = ticks_q;
    has_cmd   = 1'b0;
    cmd_o     = '{code: CMD_KEYOFF, effect: effect_i, key: 8'h00};
    case (kind_i)
      KIND_TICK: begin
        if (playing_q && ticks_q != 3'd0) begin
          ticks_d = ticks_q - 3'd1;
          if (ticks_q == 3'd1) begin
            step_d  = next_step[2:0];
            has_cmd = 1'b1;
            if (next_step >= cur_len) begin
              playing_d = 1'b0;
            end else begin
              ticks_d    = NOTE_DUR[cur_eff_q][next_step[2:0]];
              cmd_o.code = CMD_NOTE;
              cmd_o.key  = NOTE_KEY[cur_eff_q][next_step[2:0]];
            end
          end
        end
      end
      KIND_START: begin
        if (ready_q && effect_i < 4'(EFFECT_LIMIT)) begin
          has_cmd    = 1'b1;
          cmd_o.code = CMD_START;
          cmd_o.key  = NOTE_KEY[effect_i][0];
          cur_eff_d  = effect_i;
          playing_d  = 1'b1;
          step_d     = 3'd0;
          ticks_d    = NOTE_DUR[effect_i][0];
        end
      end
      KIND_STOP, KIND_FINAL: begin
        has_cmd   = ready_q;
        playing_d = 1'b0;
        cur_eff_d = 4'd0;
        step_d    = 3'd0;
        ticks_d   = 3'd0;
        if (kind_i == KIND_FINAL) ready_d = 1'b0;
      end
      KIND_INIT: begin
        has_cmd    = 1'b1;
        cmd_o.code = CMD_INIT;
        ready_d    = 1'b1;
        playing_d  = 1'b0;
        cur_eff_d  = 4'd0;
        step_d     = 3'd0;
        ticks_d    = 3'd0;
      end
      default: ;
    endcase
  end

  assign push_o = accept && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= CHANNEL_RESET;
      ready_q   <= 1'b0;
      playing_q <= 1'b0;
      cur_eff_q <= 4'd0;
      step_q    <= 3'd0;
      ticks_q   <= 3'd0;
    end else begin
      if (channel_changed) channel_q <= cfg_wdata_i;
      if (accept) begin
        ready_q   <= ready_d;
        playing_q <= playing_d;
        cur_eff_q <= cur_eff_d;
        step_q    <= step_d;
        ticks_q   <= ticks_d;
      end
    end
  end

  // a playing note always has time left and stays inside its list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> (ticks_q != 3'd0 && {1'b0, step_q} < cur_len))
    else $error("front: playing with no note left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> ready_q)
    else $error("front: playing while not initialized");

endmodule

`default_nettype wire

// ===== rtl/fses_fifo.sv =====
`default_nettype none

module fses_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  fses_pkg::cmd_t  data_i,
  output logic            full_o,
  input  wire             pop_i,
  output fses_pkg::cmd_t  data_o,
  output logic            valid_o
);
  import fses_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> valid_o))
    else $error("fifo: overflow or underflow");

endmodule

`default_nettype wire

// ===== rtl/fses_back.sv =====
`default_nettype none

module fses_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire  [2:0]      channel_i,
  input  fses_pkg::cmd_t  head_i,
  input  wire             head_valid_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output logic [7:0]      reg_addr_o,
  output logic [7:0]      reg_value_o,
  output logic            last_o
);
  import fses_pkg::*;

  typedef enum logic [1:0] {
    WR_NOTE = 2'd0,
    WR_OP   = 2'd1,
    WR_ALG  = 2'd2,
    WR_PMS  = 2'd3
  } wr_e;

  logic [4:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] addr_q, value_q;
  logic       last_q;

  logic [4:0] seq_len;
  logic       advance, load, entry_last;
  wr_e        wr;
  logic [1:0] slot;
  logic [2:0] op_reg;
  logic [1:0] part;
  logic [4:0] j;
  logic [7:0] p_mul, p_tl, p_dec;
  logic [7:0] ch8;
  logic [7:0] addr_d, value_d;

  assign ch8 = {5'd0, channel_i};
  assign j   = idx_q - 5'd3;

  always_comb begin
    wr     = WR_NOTE;
    slot   = 2'd0;
    op_reg = 3'd0;
    part   = 2'd0;
    p_mul  = 8'h00;
    p_tl   = 8'h00;
    p_dec  = 8'h00;
    unique case (head_i.code)
      CMD_KEYOFF: seq_len = LEN_KEYOFF;
      CMD_NOTE: begin
        seq_len = LEN_NOTE;
        part    = idx_q[1:0];
      end
      CMD_START: begin
        seq_len = LEN_START;
        if (idx_q < 5'd6) begin
          wr     = WR_OP;
          op_reg = idx_q[2:0];
        end else if (idx_q < 5'd12) begin
          wr     = WR_OP;
          slot   = 2'd3;
          op_reg = 3'(idx_q - 5'd6);
        end else begin
          part = 2'(idx_q - 5'd12);
        end
        if (slot == 2'd0) begin
          p_mul = PATCH[head_i.effect][0];
          p_tl  = PATCH[head_i.effect][1];
          p_dec = PATCH[head_i.effect][2];
        end else begin
          p_mul = PATCH[head_i.effect][3];
          p_tl  = PATCH[head_i.effect][4];
          p_dec = PATCH[head_i.effect][5];
        end
      end
      CMD_INIT: begin
        seq_len = LEN_INIT;
        if (idx_q == 5'd1) begin
          wr = WR_ALG;
        end else if (idx_q == 5'd2) begin
          wr = WR_PMS;
        end else if (idx_q != 5'd0) begin
          wr = WR_OP;
          // six writes per operator
          if (j >= 5'd18) begin
            slot = 2'd3; op_reg = 3'(j - 5'd18);
          end else if (j >= 5'd12) begin
            slot = 2'd2; op_reg = 3'(j - 5'd12);
          end else if (j >= 5'd6) begin
            slot = 2'd1; op_reg = 3'(j - 5'd6);
          end else begin
            op_reg = j[2:0];
          end
        end
        case (slot)
          2'd0: begin p_mul = 8'h01; p_tl = 8'h14; p_dec = 8'h18; end
          2'd1: begin p_mul = 8'h02; p_tl = 8'h7f; p_dec = 8'h00; end
          2'd2: begin p_mul = 8'h01; p_tl = 8'h7f; p_dec = 8'h00; end
          default: begin p_mul = 8'h01; p_tl = 8'h28; p_dec = 8'h1f; end
        endcase
      end
      default: seq_len = LEN_KEYOFF;
    endcase
  end

  always_comb begin
    addr_d  = KEY_ADDR;
    value_d = ch8;
    unique case (wr)
      WR_ALG: begin
        addr_d  = ALG_ADDR + ch8;
        value_d = ALG_VALUE;
      end
      WR_PMS: begin
        addr_d  = PMS_ADDR + ch8;
        value_d = 8'h00;
      end
      WR_OP: begin
        addr_d = OP_BASE_ADDR + {op_reg, 5'd0} + {3'd0, slot, 3'd0} + ch8;
        case (op_reg)
          3'd0:    value_d = p_mul;
          3'd1:    value_d = p_tl;
          3'd2:    value_d = OP_AR_VALUE;
          3'd3:    value_d = p_dec;
          3'd5:    value_d = OP_RR_VALUE;
          default: value_d = 8'h00;
        endcase
      end
      WR_NOTE: begin
        case (part)
          2'd1: begin addr_d = KEYCODE_ADDR + ch8; value_d = head_i.key; end
          2'd2: begin addr_d = FRAC_ADDR + ch8;    value_d = 8'h00;      end
          2'd3: begin addr_d = KEY_ADDR;           value_d = KEY_ON_BITS | ch8; end
          default: begin addr_d = KEY_ADDR;        value_d = ch8;        end
        endcase
      end
      default: ;
    endcase
  end

  assign entry_last = idx_q == seq_len - 5'd1;
  assign advance    = !out_valid_q || out_ready_i;
  assign load       = advance && head_valid_i;
  assign pop_o      = load && entry_last;
  assign idx_d      = entry_last ? 5'd0 : idx_q + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= idx_d;
      if (advance) out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q  <= addr_d;
      value_q <= value_d;
      last_q  <= entry_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign reg_addr_o  = addr_q;
  assign reg_value_o = value_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < seq_len)
    else $error("back: write index past end of command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(idx_q))
    else $error("back: index moved while output stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 5'd0)
    else $error("back: partial command with empty queue");

endmodule

`default_nettype wire
